// File: hw/rtl/i2c_bit_level_master_core_assert.svh
// ----------------------------------------------------------------------------
// I2C bit-level master - assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef I2C_BIT_LEVEL_MASTER_CORE_ASSERT_SVH
`define I2C_BIT_LEVEL_MASTER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define I2CM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define I2CM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C bit-level master - package
// Types, command codes and constants shared by the core's modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cm_pkg;

  localparam logic [15:0] PHASE_TICKS_RESET = 16'd250;
  localparam logic [7:0]  ACK_MASK          = 8'h80;

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_STOP  = 3'd1,
    OP_WRITE = 3'd2,
    OP_READ  = 3'd3,
    OP_WAIT  = 3'd4,
    OP_ACK   = 3'd5,
    OP_NACK  = 3'd6
  } op_e;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] write_byte;
    logic [7:0] line_bits;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic [7:0] read_data;
    logic       ack_missing;
    logic       last_phase;
  } out_item_t;

  typedef struct packed {
    op_e        op;
    logic [7:0] write_byte;
    logic [7:0] line_bits;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EMIT,
    BK_HOLD
  } bk_state_e;

endpackage

// File: hw/rtl/i2c_bit_level_master_core.sv
// ----------------------------------------------------------------------------
// I2C bit-level master - top level
// Turns I2C commands into timed SCL/SDA bus phases, one result beat a phase.
// ----------------------------------------------------------------------------
// Each input beat is one command: start, stop, write byte, read byte, wait
// for acknowledge, send ack or send nack (the unused code 7 is accepted and
// dropped). The core answers with one output beat per bus phase: start 3,
// stop 2, write 24, read 16, wait ack 3, ack 4, nack 3. The last beat of a
// command has last_phase set and carries read_data (read) or ack_missing
// (wait ack). SDA levels the slave drives are supplied up front in
// line_bits, MSB first. Timing: a phase passes through a set-up state
// (BK_EMIT) and a hold state (BK_HOLD) timed by phase_ticks; its beat can
// be taken from the hold state on, and the hold does not end before its
// beat has been taken. The phase hold counter in the sequencer sets the
// hold length; a two-entry command queue lets the next commands be taken
// in meanwhile.
// phase_ticks is written through the cfg_ port (always ready) and resets to
// 250; write it only while the core is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_bit_level_master_core import i2cm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // command beats
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  // phase beats
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  // phase_ticks register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [15:0] phase_ticks_r;
  logic        q_push, q_pop;
  cmd_t        q_push_cmd, q_pop_cmd;
  q_stat_t     q_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= PHASE_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      phase_ticks_r <= cfg_data;
    end
  end

  // Front: decode and queue
  i2cm_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_stat   (q_stat),
    .push     (q_push),
    .push_cmd (q_push_cmd)
  );

  i2cm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .pop      (q_pop),
    .pop_cmd  (q_pop_cmd),
    .stat     (q_stat)
  );

  // Back: phase sequencer with the output register
  i2cm_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .phase_ticks (phase_ticks_r),
    .q_stat      (q_stat),
    .q_cmd       (q_pop_cmd),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

endmodule

// File: hw/rtl/i2cm_queue.sv
// ----------------------------------------------------------------------------
// I2C bit-level master - command queue
// Short FIFO of decoded commands between the front end and the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cm_queue import i2cm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    pop_cmd,
  output q_stat_t stat
);

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_cmd    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: hw/rtl/i2cm_front.sv
// ----------------------------------------------------------------------------
// I2C bit-level master - front end
// Takes input beats, decodes the operation and queues the valid commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cm_front import i2cm_pkg::*; (
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  input  q_stat_t  q_stat,
  output logic     push,
  output cmd_t     push_cmd
);

  logic op_ok;

  // Reserved code is swallowed: accepted, never queued.
  always_comb begin
    case (in_item.operation)
      OP_START, OP_STOP, OP_WRITE, OP_READ,
      OP_WAIT, OP_ACK, OP_NACK: op_ok = 1'b1;
      default:                  op_ok = 1'b0;
    endcase
  end

  assign in_stall            = q_stat.full;
  assign push                = in_valid && !q_stat.full && op_ok;
  assign push_cmd.op         = op_e'(in_item.operation);
  assign push_cmd.write_byte = in_item.write_byte;
  assign push_cmd.line_bits  = in_item.line_bits;

endmodule

// File: hw/rtl/i2cm_back.sv
// ----------------------------------------------------------------------------
// I2C bit-level master - phase sequencer
// Steps one command through its bus phases and holds each for the set ticks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cm_back import i2cm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] phase_ticks,
  input  q_stat_t     q_stat,
  input  cmd_t        q_cmd,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item
);

  bk_state_e   state_r, state_nxt;
  cmd_t        cmd_r;
  logic [1:0]  sub_r;
  logic [2:0]  bit_r;
  logic [15:0] tick_r;
  logic        scl_hold_r;
  logic        last_r;
  logic        out_valid_r;
  out_item_t   out_r;

  logic        emit, hold_done;
  logic        ph_scl, ph_sda, ph_am, grp_end, cmd_end, wbit, last_bit;
  logic [7:0]  ph_rd;

  assign last_bit = (bit_r == 3'd7);
  assign wbit     = cmd_r.write_byte[~bit_r];

  // Phase table: level pair for the current step of the command
  always_comb begin
    ph_scl  = 1'b1;
    ph_sda  = 1'b1;
    ph_rd   = '0;
    ph_am   = 1'b0;
    grp_end = 1'b1;
    case (cmd_r.op)
      OP_START: begin
        ph_scl  = (sub_r != 2'd2);
        ph_sda  = (sub_r == 2'd0);
        grp_end = (sub_r == 2'd2);
      end
      OP_STOP: begin
        ph_scl  = 1'b1;
        ph_sda  = (sub_r != 2'd0);
        grp_end = (sub_r == 2'd1);
      end
      OP_WRITE: begin
        case (sub_r)
          2'd0:    ph_scl = scl_hold_r;
          2'd1:    ph_scl = 1'b1;
          default: ph_scl = 1'b0;
        endcase
        // SDA let go on the last low phase so the slave can acknowledge
        ph_sda  = (sub_r == 2'd2 && last_bit) ? 1'b1 : wbit;
        grp_end = (sub_r == 2'd2);
      end
      OP_READ: begin
        ph_scl  = (sub_r == 2'd0);
        ph_sda  = 1'b1;
        grp_end = (sub_r == 2'd1);
        // after eight samples the byte read equals line_bits
        ph_rd   = (grp_end && last_bit) ? cmd_r.line_bits : '0;
      end
      OP_WAIT, OP_NACK: begin
        case (sub_r)
          2'd0:    ph_scl = scl_hold_r;
          2'd1:    ph_scl = 1'b1;
          default: ph_scl = 1'b0;
        endcase
        ph_sda  = 1'b1;
        grp_end = (sub_r == 2'd2);
        ph_am   = (cmd_r.op == OP_WAIT) && grp_end &&
                  ((cmd_r.line_bits & ACK_MASK) != '0);
      end
      OP_ACK: begin
        case (sub_r)
          2'd0:    ph_scl = scl_hold_r;
          2'd1:    ph_scl = 1'b1;
          default: ph_scl = 1'b0;
        endcase
        ph_sda  = (sub_r == 2'd3);
        grp_end = (sub_r == 2'd3);
      end
      default: begin
        grp_end = 1'b1;
      end
    endcase
  end

  assign cmd_end   = grp_end && (!(cmd_r.op == OP_WRITE || cmd_r.op == OP_READ) || last_bit);
  assign hold_done = (tick_r == 16'd1) && !out_valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = BK_EMIT;
        end
      end
      BK_EMIT: begin
        state_nxt = BK_HOLD;
      end
      BK_HOLD: begin
        if (hold_done) begin
          state_nxt = last_r ? BK_IDLE : BK_EMIT;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // State outputs
  always_comb begin
    pop  = 1'b0;
    emit = 1'b0;
    case (state_r)
      BK_IDLE: pop  = !q_stat.empty;
      BK_EMIT: emit = 1'b1;
      default: begin
        pop  = 1'b0;
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      sub_r       <= '0;
      bit_r       <= '0;
      tick_r      <= '0;
      scl_hold_r  <= 1'b1;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (pop) begin
        sub_r <= '0;
        bit_r <= '0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
        scl_hold_r  <= ph_scl;
        last_r      <= cmd_end;
        tick_r      <= (phase_ticks == '0) ? 16'd1 : phase_ticks;
        if (grp_end) begin
          sub_r <= '0;
          bit_r <= bit_r + 1'b1;
        end else begin
          sub_r <= sub_r + 1'b1;
        end
      end else if (state_r == BK_HOLD && tick_r != 16'd1) begin
        tick_r <= tick_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r <= q_cmd;
    end
    if (emit) begin
      out_r.scl_level   <= ph_scl;
      out_r.sda_level   <= ph_sda;
      out_r.read_data   <= ph_rd;
      out_r.ack_missing <= ph_am;
      out_r.last_phase  <= cmd_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// File: hw/rtl/i2cm_checker.sv
// ----------------------------------------------------------------------------
// I2C bit-level master - port checker
// Watches the result channel of the core and is bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "i2c_bit_level_master_core_assert.svh"

module i2cm_checker import i2cm_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // stalled beat holds
  `I2CM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "stalled phase beat changed")

  // no new phase beat in the cycle after one is taken
  `I2CM_ASSERT_NEXT(a_out_gap, out_valid && !out_stall, !out_valid, "phase beats back to back")

  `I2CM_ASSERT_NOW(a_ack_last, out_valid && out_item.ack_missing, out_item.last_phase, "ack_missing off last phase")

  `I2CM_ASSERT_NOW(a_rd_last, out_valid && (out_item.read_data != 8'h00), out_item.last_phase, "read_data off last phase")

endmodule

bind i2c_bit_level_master_core i2cm_checker u_i2cm_checker (.*);

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// I2C bit-level master - testbench
// Drives command beats into the core and checks every bus phase beat that
// comes back against a behavioural forecast of the SCL/SDA sequence.
// ----------------------------------------------------------------------------
// A short scripted run covers every command, the byte extremes, both
// acknowledge outcomes and the unused code. phase_ticks is then taken to its
// top value for one short command. The rest is mostly well-formed transfers
// with random content (start, address, ack, data, stop) plus some noise. The
// timing register is rewritten only with the core idle. Both handshakes get
// random gaps, with stretches of none.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import i2cm_pkg::*;

  // code 7 has no enum member: the core accepts and drops it
  localparam logic [2:0] OP_UNUSED   = 3'd7;
  localparam out_item_t  NO_BEAT     = '0;
  localparam int         RANDOM_CMDS = 75;
  localparam int         CHUNK_CMDS  = 25;

  // one scripted command; where pinned, tail is the hand-written last beat
  typedef struct packed {
    in_item_t  cmd;
    logic      pinned;
    out_item_t tail;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  out_item_t   phase_q[$];   // phase beats still owed by the core, oldest first
  logic        bus_scl;      // SCL level left by the last forecast phase
  logic [15:0] ticks_now;
  bit          quiet;        // no gaps on either side while set
  int          faults;
  int          beats_seen;
  int          cmds_sent;
  int          settings_used;
  row_t        script[$];

  i2c_bit_level_master_core uut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Forecast of the bus phases
  // --------------------------------------------------------------------------
  function automatic out_item_t beat(logic scl, logic sda, logic [7:0] rd,
                                     logic am, logic last);
    out_item_t b;
    b.scl_level   = scl;
    b.sda_level   = sda;
    b.read_data   = rd;
    b.ack_missing = am;
    b.last_phase  = last;
    return b;
  endfunction

  function automatic in_item_t cmd_of(logic [2:0] op, logic [7:0] wb, logic [7:0] lb);
    in_item_t c;
    c.operation  = op;
    c.write_byte = wb;
    c.line_bits  = lb;
    return c;
  endfunction

  function automatic row_t entry(logic [2:0] op, logic [7:0] wb, logic [7:0] lb,
                                 logic pin, out_item_t tail);
    row_t r;
    r.cmd    = cmd_of(op, wb, lb);
    r.pinned = pin;
    r.tail   = tail;
    return r;
  endfunction

  function automatic void add_phase(logic scl, logic sda, logic [7:0] rd,
                                    logic am, logic last);
    phase_q.push_back(beat(scl, sda, rd, am, last));
    bus_scl = scl;
  endfunction

  // Appends the phases one command owes. The first phase of write, wait,
  // ack and nack keeps whatever SCL level the previous command left.
  function automatic void forecast_phases(in_item_t c);
    logic [7:0] sh;
    logic [7:0] acc;
    case (c.operation)
      OP_START: begin
        add_phase(1'b1, 1'b1, 8'h00, 1'b0, 1'b0);
        add_phase(1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
        add_phase(1'b0, 1'b0, 8'h00, 1'b0, 1'b1);
      end
      OP_STOP: begin
        add_phase(1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
        add_phase(1'b1, 1'b1, 8'h00, 1'b0, 1'b1);
      end
      OP_WRITE: begin
        sh = c.write_byte;
        for (int i = 0; i < 8; i++) begin
          add_phase(bus_scl, sh[7], 8'h00, 1'b0, 1'b0);
          add_phase(1'b1, sh[7], 8'h00, 1'b0, 1'b0);
          // SDA let go on the final low phase so the slave can acknowledge
          if (i == 7) add_phase(1'b0, 1'b1, 8'h00, 1'b0, 1'b1);
          else        add_phase(1'b0, sh[7], 8'h00, 1'b0, 1'b0);
          sh = sh << 1;
        end
      end
      OP_READ: begin
        acc = 8'h00;
        for (int i = 0; i < 8; i++) begin
          acc = {acc[6:0], c.line_bits[7 - i]};
          add_phase(1'b1, 1'b1, 8'h00, 1'b0, 1'b0);
          if (i == 7) add_phase(1'b0, 1'b1, acc, 1'b0, 1'b1);
          else        add_phase(1'b0, 1'b1, 8'h00, 1'b0, 1'b0);
        end
      end
      OP_WAIT: begin
        add_phase(bus_scl, 1'b1, 8'h00, 1'b0, 1'b0);
        add_phase(1'b1, 1'b1, 8'h00, 1'b0, 1'b0);
        add_phase(1'b0, 1'b1, 8'h00, (c.line_bits & ACK_MASK) != 8'h00, 1'b1);
      end
      OP_ACK: begin
        add_phase(bus_scl, 1'b0, 8'h00, 1'b0, 1'b0);
        add_phase(1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
        add_phase(1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
        add_phase(1'b0, 1'b1, 8'h00, 1'b0, 1'b1);
      end
      OP_NACK: begin
        add_phase(bus_scl, 1'b1, 8'h00, 1'b0, 1'b0);
        add_phase(1'b1, 1'b1, 8'h00, 1'b0, 1'b0);
        add_phase(1'b0, 1'b1, 8'h00, 1'b0, 1'b1);
      end
      default: ;  // unused code: nothing on the bus
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Command side
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  // Valid is only ever lowered and raised on different falling edges.
  task automatic issue_cmd(in_item_t c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    forecast_phases(c);
    if (c.operation != OP_UNUSED) cmds_sent++;
  endtask

  task automatic drain();
    @(negedge clk) in_valid <= 1'b0;
    while (phase_q.size() != 0) @(posedge clk);
  endtask

  // After the last beat the core may still hold that phase, and a dropped
  // code 7 leaves nothing to wait on, so allow a phase and some margin.
  task automatic settle();
    drain();
    repeat (int'(ticks_now) + 32) @(posedge clk);
  endtask

  task automatic set_ticks(logic [15:0] v);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk) cfg_valid <= 1'b0;
    ticks_now = v;
    settings_used++;
  endtask

  // --------------------------------------------------------------------------
  // Phase side: random stalls, mostly short, now and then long
  // --------------------------------------------------------------------------
  initial begin : backpressure
    int stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                 : $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Every taken phase beat is matched against the oldest one owed
  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      beats_seen++;
      if (phase_q.size() == 0) begin
        $error("phase beat with nothing owed: %h", out_item);
        faults++;
      end else begin
        want = phase_q.pop_front();
        if (out_item.scl_level !== want.scl_level) begin
          $error("scl_level: expected %0d, got %0d", want.scl_level, out_item.scl_level);
          faults++;
        end
        if (out_item.sda_level !== want.sda_level) begin
          $error("sda_level: expected %0d, got %0d", want.sda_level, out_item.sda_level);
          faults++;
        end
        if (out_item.read_data !== want.read_data) begin
          $error("read_data: expected %h, got %h", want.read_data, out_item.read_data);
          faults++;
        end
        if (out_item.ack_missing !== want.ack_missing) begin
          $error("ack_missing: expected %0d, got %0d", want.ack_missing,
                 out_item.ack_missing);
          faults++;
        end
        if (out_item.last_phase !== want.last_phase) begin
          $error("last_phase: expected %0d, got %0d", want.last_phase,
                 out_item.last_phase);
          faults++;
        end
      end
    end
  end

  // Backstop: the slowest clean run is well under a quarter of this
  initial begin
    #(30_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int base;
    int chunk;
    int chunk_at;
    int n;
    logic rd_mode;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_item       = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    quiet         = 1'b0;
    bus_scl       = 1'b1;
    ticks_now     = PHASE_TICKS_RESET;
    faults        = 0;
    beats_seen    = 0;
    cmds_sent     = 0;
    settings_used = 1;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // scripted run at the reset timing
    script.push_back(entry(OP_START, 8'h00, 8'h00, 1'b1, beat(1'b0, 1'b0, 8'h00, 1'b0, 1'b1)));
    script.push_back(entry(OP_WRITE, 8'h00, 8'h00, 1'b1, beat(1'b0, 1'b1, 8'h00, 1'b0, 1'b1)));
    script.push_back(entry(OP_WAIT,  8'h00, 8'h00, 1'b1, beat(1'b0, 1'b1, 8'h00, 1'b0, 1'b1)));
    script.push_back(entry(OP_WRITE, 8'hFF, 8'hFF, 1'b0, NO_BEAT));
    script.push_back(entry(OP_WAIT,  8'h00, 8'h80, 1'b1, beat(1'b0, 1'b1, 8'h00, 1'b1, 1'b1)));
    script.push_back(entry(OP_WRITE, 8'hA5, 8'h00, 1'b0, NO_BEAT));
    script.push_back(entry(OP_WAIT,  8'hFF, 8'h7F, 1'b1, beat(1'b0, 1'b1, 8'h00, 1'b0, 1'b1)));
    script.push_back(entry(OP_READ,  8'hFF, 8'h00, 1'b1, beat(1'b0, 1'b1, 8'h00, 1'b0, 1'b1)));
    script.push_back(entry(OP_ACK,   8'h00, 8'h00, 1'b1, beat(1'b0, 1'b1, 8'h00, 1'b0, 1'b1)));
    script.push_back(entry(OP_READ,  8'h00, 8'hFF, 1'b1, beat(1'b0, 1'b1, 8'hFF, 1'b0, 1'b1)));
    script.push_back(entry(OP_NACK,  8'hFF, 8'hFF, 1'b1, beat(1'b0, 1'b1, 8'h00, 1'b0, 1'b1)));
    script.push_back(entry(OP_READ,  8'h00, 8'h5A, 1'b0, NO_BEAT));
    script.push_back(entry(OP_ACK,   8'hFF, 8'hFF, 1'b0, NO_BEAT));
    script.push_back(entry(OP_STOP,  8'h00, 8'h00, 1'b1, beat(1'b1, 1'b1, 8'h00, 1'b0, 1'b1)));
    // unused code, all payload bits high: must be swallowed
    script.push_back(entry(OP_UNUSED, 8'hFF, 8'hFF, 1'b0, NO_BEAT));
    // wait ack straight after stop starts from SCL high
    script.push_back(entry(OP_WAIT,  8'h00, 8'hFF, 1'b1, beat(1'b0, 1'b1, 8'h00, 1'b1, 1'b1)));
    script.push_back(entry(OP_ACK,   8'h00, 8'h00, 1'b0, NO_BEAT));
    script.push_back(entry(OP_WRITE, 8'h80, 8'h00, 1'b0, NO_BEAT));
    script.push_back(entry(OP_UNUSED, 8'h00, 8'h00, 1'b0, NO_BEAT));
    script.push_back(entry(OP_NACK,  8'h00, 8'h00, 1'b0, NO_BEAT));
    script.push_back(entry(OP_START, 8'hFF, 8'hFF, 1'b0, NO_BEAT));
    script.push_back(entry(OP_WRITE, 8'h01, 8'h00, 1'b0, NO_BEAT));
    script.push_back(entry(OP_STOP,  8'hFF, 8'hFF, 1'b0, NO_BEAT));
    script.push_back(entry(OP_READ,  8'h00, 8'h80, 1'b1, beat(1'b0, 1'b1, 8'h80, 1'b0, 1'b1)));

    foreach (script[i]) begin
      quiet = ((i / 6) % 2) == 1;
      issue_cmd(script[i].cmd);
      if (script[i].pinned) phase_q[phase_q.size() - 1] = script[i].tail;
    end

    // register at its ceiling: one short command only, it is slow
    set_ticks(16'hFFFF);
    quiet = 1'b1;
    issue_cmd(cmd_of(OP_STOP, 8'h00, 8'h00));

    // random transfers; timing register moves every chunk, zero and one first
    base     = cmds_sent;
    chunk    = 0;
    chunk_at = 0;
    while (cmds_sent - base < RANDOM_CMDS) begin
      if (cmds_sent - base >= chunk_at) begin
        set_ticks(chunk == 0 ? 16'd0 : chunk == 1 ? 16'd1 : 16'($urandom_range(2, 12)));
        chunk++;
        chunk_at += CHUNK_CMDS;
      end
      quiet = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) begin
        // noise: any code, unused one included
        repeat ($urandom_range(1, 3))
          issue_cmd(cmd_of(3'($urandom_range(0, 7)), rnd8(), rnd8()));
      end else begin
        issue_cmd(cmd_of(OP_START, rnd8(), rnd8()));
        issue_cmd(cmd_of(OP_WRITE, rnd8(), rnd8()));
        issue_cmd(cmd_of(OP_WAIT, rnd8(), rnd8()));
        n       = $urandom_range(0, 3);
        rd_mode = 1'($urandom_range(0, 1));
        for (int k = 0; k < n; k++) begin
          if (rd_mode) begin
            issue_cmd(cmd_of(OP_READ, rnd8(), rnd8()));
            issue_cmd(cmd_of(k == n - 1 ? OP_NACK : OP_ACK, rnd8(), rnd8()));
          end else begin
            issue_cmd(cmd_of(OP_WRITE, rnd8(), rnd8()));
            issue_cmd(cmd_of(OP_WAIT, rnd8(), rnd8()));
          end
        end
        // now and then the stop goes missing
        if ($urandom_range(0, 7) != 0)
          issue_cmd(cmd_of(OP_STOP, rnd8(), rnd8()));
        // sender holds off until the bus has caught up
        if ($urandom_range(0, 5) == 0) drain();
      end
    end

    settle();
    $display("Checked %0d phase beats from %0d commands", beats_seen, cmds_sent);
    $display("across %0d phase_ticks settings, from zero to 65535", settings_used);
    if (faults == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
